// ----- src/bgi_pkg.sv -----
// Package for the Bayer green interpolation block.
// Holds pixel, site and register types, line store word layout and stage structs.
// No dependencies; compiled first.
package bgi_pkg;

	localparam int PIXEL_W        = 8;
	localparam int DIM_CFG_W      = 13;
	localparam int DEF_MAX_WIDTH  = 4096;
	localparam int DEF_MAX_HEIGHT = 4096;
	localparam int RST_WIDTH      = 640;
	localparam int RST_HEIGHT     = 480;
	localparam int APB_ADDR_W     = 3;
	localparam int APB_DATA_W     = 32;
	localparam int LANES          = 4;
	localparam int LANE_W         = 2;

	typedef logic [PIXEL_W-1:0] pixel_t;

	typedef enum logic [1:0] {
		SITE_RED   = 2'd0,
		SITE_GREEN = 2'd1,
		SITE_BLUE  = 2'd2
	} site_t;

	typedef enum logic [0:0] {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} reg_idx_t;

	// one line store word: the same column of four rows, lane = row mod 4
	typedef logic [LANES-1:0][PIXEL_W-1:0] ls_word_t;

	typedef struct packed {
		logic              rd_en;
		logic              wr_en;
		logic [LANE_W-1:0] wr_lane;
		pixel_t            wr_byte;
	} ls_ctrl_t;

	typedef struct packed {
		pixel_t x5;
		pixel_t g2;
		pixel_t g4;
		pixel_t g6;
		pixel_t g8;
		pixel_t x1;
		pixel_t x3;
		pixel_t x7;
		pixel_t x9;
		site_t  site;
		logic   last;
	} bgi_cross_t;

	typedef struct packed {
		pixel_t green;
		pixel_t mosaic_value;
		site_t  site_color;
		logic   last_of_frame;
	} bgi_result_t;

endpackage

// ----- src/bgi_pix_if.sv -----
// Mosaic pixel stream channel: valid/ready handshake with pixel and drain flag.
// Depends on bgi_pkg.
interface bgi_pix_if import bgi_pkg::*; ();
	logic   valid;
	logic   ready;
	pixel_t raw_pixel;
	logic   drain;

	modport source (output valid, output raw_pixel, output drain, input ready);
	modport sink (input valid, input raw_pixel, input drain, output ready);
endinterface

// ----- src/bgi_res_if.sv -----
// Green result stream channel: valid/ready handshake with result fields.
// Depends on bgi_pkg.
interface bgi_res_if import bgi_pkg::*; ();
	logic        valid;
	logic        ready;
	pixel_t      green;
	pixel_t      mosaic_value;
	logic [1:0]  site_color;
	logic        last_of_frame;

	modport source (output valid, output green, output mosaic_value, output site_color,
		output last_of_frame, input ready);
	modport sink (input valid, input green, input mosaic_value, input site_color,
		input last_of_frame, output ready);
endinterface

// ----- src/bgi_regs.sv -----
// APB register file for frame width and height, with range clamping.
// Any write raises a one-cycle restart. Depends on bgi_pkg.
module bgi_regs import bgi_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
	localparam int WD_W = $clog2(MAX_WIDTH + 1),
	localparam int HD_W = $clog2(MAX_HEIGHT + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	output logic [WD_W-1:0]       frame_w,
	output logic [HD_W-1:0]       frame_h,
	output logic                  restart
);

	localparam int CW = (DIM_CFG_W > WD_W) ? DIM_CFG_W : WD_W;
	localparam int CH = (DIM_CFG_W > HD_W) ? DIM_CFG_W : HD_W;

	logic [DIM_CFG_W-1:0] width_q;
	logic [DIM_CFG_W-1:0] height_q;
	reg_idx_t             idx;
	logic                 wr;
	logic [CW-1:0]        wext;
	logic [CH-1:0]        hext;

	assign idx     = reg_idx_t'(paddr[APB_ADDR_W-1]);
	assign pready  = 1'b1;
	assign wr      = psel && penable && pwrite;
	assign restart = wr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_CFG_W'(RST_WIDTH);
			height_q <= DIM_CFG_W'(RST_HEIGHT);
		end else if (wr) begin
			case (idx)
				REG_FRAME_WIDTH: begin
					width_q <= pwdata[DIM_CFG_W-1:0];
				end
				REG_FRAME_HEIGHT: begin
					height_q <= pwdata[DIM_CFG_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_FRAME_WIDTH:  prdata = APB_DATA_W'(width_q);
			REG_FRAME_HEIGHT: prdata = APB_DATA_W'(height_q);
			default:          prdata = '0;
		endcase
	end

	assign wext = CW'(width_q);
	assign hext = CH'(height_q);

	always_comb begin
		if (wext == '0) begin
			frame_w = WD_W'(1);
		end else if (wext > CW'(MAX_WIDTH)) begin
			frame_w = WD_W'(MAX_WIDTH);
		end else begin
			frame_w = WD_W'(wext);
		end
		if (hext == '0) begin
			frame_h = HD_W'(1);
		end else if (hext > CH'(MAX_HEIGHT)) begin
			frame_h = HD_W'(MAX_HEIGHT);
		end else begin
			frame_h = HD_W'(hext);
		end
	end

endmodule

// ----- src/bgi_line_store.sv -----
// Line store: one word per column holding four rows, read-modify-write per pixel.
// Registered read, forwards a same-address write. Depends on bgi_pkg.
module bgi_line_store import bgi_pkg::*; #(
	parameter int DEPTH = DEF_MAX_WIDTH,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic     clk,
	input  ls_ctrl_t ctrl,
	input  logic [AW-1:0] rd_addr,
	input  logic [AW-1:0] wr_addr,
	output ls_word_t rd_data
);

	ls_word_t mem_q [DEPTH];
	ls_word_t rd_q;
	ls_word_t merged;

	always_comb begin
		merged = rd_q;
		merged[ctrl.wr_lane] = ctrl.wr_byte;
	end

	always_ff @(posedge clk) begin
		if (ctrl.wr_en) begin
			mem_q[wr_addr] <= merged;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.rd_en) begin
			rd_q <= (ctrl.wr_en && (wr_addr == rd_addr)) ? merged : mem_q[rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule

// ----- src/bgi_interp.sv -----
// Green interpolation datapath: gradient stage then select, divide and saturate stage.
// Takes the masked cross neighbourhood, drives the result register. Depends on bgi_pkg.
module bgi_interp import bgi_pkg::*; (
	input  logic        clk,
	input  logic        en_s3,
	input  logic        en_s4,
	input  bgi_cross_t  nbhd,
	output bgi_result_t result
);

	function automatic logic [9:0] abs11(input logic signed [10:0] v);
		abs11 = (v < 0) ? 10'(-v) : 10'(v);
	endfunction

	logic signed [10:0] eh, ev, e4;
	logic [7:0]         gdh, gdv;
	logic [9:0]         dh, dv, sum4;
	logic [8:0]         sum_h, sum_v;

	logic signed [10:0] eh_s3, ev_s3, e4_s3;
	logic [9:0]         dh_s3, dv_s3, sum4_s3;
	logic [8:0]         sum_h_s3, sum_v_s3;
	pixel_t             x5_s3;
	site_t              site_s3;
	logic               last_s3;

	logic signed [10:0] qh, qv, q4, cand;
	pixel_t             sat;
	bgi_result_t        res_s4;

	always_comb begin
		eh = $signed({2'b00, nbhd.x5, 1'b0}) - $signed({3'b000, nbhd.x3})
			- $signed({3'b000, nbhd.x7});
		ev = $signed({2'b00, nbhd.x5, 1'b0}) - $signed({3'b000, nbhd.x1})
			- $signed({3'b000, nbhd.x9});
		e4 = eh + ev;
		gdh = (nbhd.g4 > nbhd.g6) ? nbhd.g4 - nbhd.g6 : nbhd.g6 - nbhd.g4;
		gdv = (nbhd.g2 > nbhd.g8) ? nbhd.g2 - nbhd.g8 : nbhd.g8 - nbhd.g2;
		dh = 10'(gdh) + abs11(eh);
		dv = 10'(gdv) + abs11(ev);
		sum_h = 9'(nbhd.g4) + 9'(nbhd.g6);
		sum_v = 9'(nbhd.g2) + 9'(nbhd.g8);
		sum4 = 10'(nbhd.g2) + 10'(nbhd.g4) + 10'(nbhd.g6) + 10'(nbhd.g8);
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			eh_s3    <= eh;
			ev_s3    <= ev;
			e4_s3    <= e4;
			dh_s3    <= dh;
			dv_s3    <= dv;
			sum_h_s3 <= sum_h;
			sum_v_s3 <= sum_v;
			sum4_s3  <= sum4;
			x5_s3    <= nbhd.x5;
			site_s3  <= nbhd.site;
			last_s3  <= nbhd.last;
		end
	end

	// signed divide by a power of two, rounded toward zero
	always_comb begin
		qh = (eh_s3 + ((eh_s3 < 0) ? 11'sd3 : 11'sd0)) >>> 2;
		qv = (ev_s3 + ((ev_s3 < 0) ? 11'sd3 : 11'sd0)) >>> 2;
		q4 = (e4_s3 + ((e4_s3 < 0) ? 11'sd7 : 11'sd0)) >>> 3;
		if (dh_s3 < dv_s3) begin
			cand = $signed({3'b000, sum_h_s3[8:1]}) + qh;
		end else if (dh_s3 > dv_s3) begin
			cand = $signed({3'b000, sum_v_s3[8:1]}) + qv;
		end else begin
			cand = $signed({3'b000, sum4_s3[9:2]}) + q4;
		end
		if (cand < 0) begin
			sat = '0;
		end else if (cand > 11'sd255) begin
			sat = '1;
		end else begin
			sat = cand[7:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4) begin
			res_s4.green         <= (site_s3 == SITE_GREEN) ? x5_s3 : sat;
			res_s4.mosaic_value  <= x5_s3;
			res_s4.site_color    <= site_s3;
			res_s4.last_of_frame <= last_s3;
		end
	end

	assign result = res_s4;

endmodule

// ----- src/bayer_green_interpolation.sv -----
// Bayer green interpolation top level: frame counters, line store access,
// cross window and stage control. Depends on bgi_pkg, bgi_pix_if, bgi_res_if,
// bgi_regs, bgi_line_store and bgi_interp.
//
//  channel | dir | fields                                          | handshake
//  pix     | in  | raw_pixel[7:0], drain                           | valid/ready
//  res     | out | green[7:0], mosaic_value[7:0], site_color[1:0], | valid/ready
//          |     | last_of_frame                                   |
//  apb     | in  | frame_width @0x0, frame_height @0x4             | psel/penable
//
// One pixel per clock while stage 1 is not held; stage 1, stage 2 and stage 3 registers lead to the result register.
// The result of a pixel leaves once the stream is 2*width+2 pixels past it.
// The line store RAM does at most one column read and one column write per cycle.
// Reset clears counters and stage valids only; no RAM clearing pass.
// A stalled output backs up stage by stage; pix.ready drops when stage 1 is held.
module bayer_green_interpolation import bgi_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	bgi_pix_if.sink               pix,
	bgi_res_if.source             res,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	localparam int WD_W  = $clog2(MAX_WIDTH + 1);
	localparam int HD_W  = $clog2(MAX_HEIGHT + 1);
	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int RO_W  = $clog2(MAX_HEIGHT);
	localparam int IR_W  = $clog2(MAX_HEIGHT + 4);

	logic [WD_W-1:0]  frame_w;
	logic [HD_W-1:0]  frame_h;
	logic             restart;

	logic [COL_W-1:0] in_col_q;
	logic [IR_W-1:0]  in_row_q;
	logic [COL_W-1:0] out_col_q;
	logic [RO_W-1:0]  out_row_q;

	logic             rdy1, rdy2, rdy3, rdy4;
	logic             in_fire, noop, fresh_frame, row_ge_h;
	logic [IR_W-1:0]  prow;
	logic [COL_W-1:0] pcol, ocol;
	logic [RO_W-1:0]  orow;
	logic             emit0, last0, col_wrap, ocol_wrap;

	logic             valid_s1, valid_s2, valid_s3, valid_s4;
	logic [LANE_W-1:0] lane_s1;
	logic [COL_W-1:0] col_s1;
	logic             have_s1, emit_s1, last_s1;
	pixel_t           px_s1;
	logic [RO_W-1:0]  r_s1, r_s2;
	logic [COL_W-1:0] c_s1, c_s2;
	logic             last_s2;

	ls_ctrl_t         ls_ctrl;
	ls_word_t         ls_rd;
	pixel_t           fresh [5];
	pixel_t           win_q [5][5];
	logic             shift1;

	logic [HD_W:0]    r2e, he;
	logic [WD_W:0]    c2e, we;
	site_t            site2;
	bgi_cross_t       nbhd;
	bgi_result_t      result;

	bgi_regs #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.frame_w(frame_w),
		.frame_h(frame_h),
		.restart(restart)
	);

	// stage handshake
	assign rdy4      = !valid_s4 || res.ready;
	assign rdy3      = !valid_s3 || rdy4;
	assign rdy2      = !valid_s2 || rdy3;
	assign rdy1      = !valid_s1 || rdy2;
	assign pix.ready = rdy1;
	assign in_fire   = pix.valid && rdy1;

	// frame position of the incoming transfer
	always_comb begin
		row_ge_h    = in_row_q >= IR_W'(frame_h);
		noop        = pix.drain && !row_ge_h;
		fresh_frame = !pix.drain && row_ge_h;
		prow        = fresh_frame ? '0 : in_row_q;
		pcol        = fresh_frame ? '0 : in_col_q;
		orow        = fresh_frame ? '0 : out_row_q;
		ocol        = fresh_frame ? '0 : out_col_q;
		if (frame_w == WD_W'(1)) begin
			emit0 = prow >= IR_W'(4);
		end else begin
			emit0 = (prow >= IR_W'(3)) || ((prow == IR_W'(2)) && (pcol >= COL_W'(2)));
		end
		col_wrap  = (WD_W'(pcol) + WD_W'(1)) >= frame_w;
		ocol_wrap = (WD_W'(ocol) + WD_W'(1)) >= frame_w;
		last0     = emit0 && ((HD_W'(orow) + HD_W'(1)) >= frame_h) && ocol_wrap;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (restart) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (in_fire && !noop) begin
			if (last0) begin
				in_col_q  <= '0;
				in_row_q  <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
			end else begin
				in_col_q <= col_wrap ? '0 : pcol + COL_W'(1);
				in_row_q <= col_wrap ? prow + IR_W'(1) : prow;
				if (emit0) begin
					out_col_q <= ocol_wrap ? '0 : ocol + COL_W'(1);
					out_row_q <= ocol_wrap ? orow + RO_W'(1) : orow;
				end else begin
					out_col_q <= ocol;
					out_row_q <= orow;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (rdy1) begin
				valid_s1 <= in_fire && !noop;
			end
			if (rdy2) begin
				valid_s2 <= valid_s1 && emit_s1;
			end
			if (rdy3) begin
				valid_s3 <= valid_s2;
			end
			if (rdy4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			lane_s1 <= prow[LANE_W-1:0];
			col_s1  <= pcol;
			have_s1 <= !pix.drain;
			px_s1   <= pix.raw_pixel;
			emit_s1 <= emit0;
			last_s1 <= last0;
			r_s1    <= orow;
			c_s1    <= ocol;
		end
	end

	// line store: read the column on transfer, write it back from stage 1
	assign shift1          = valid_s1 && rdy2;
	assign ls_ctrl.rd_en   = in_fire;
	assign ls_ctrl.wr_en   = shift1 && have_s1;
	assign ls_ctrl.wr_lane = lane_s1;
	assign ls_ctrl.wr_byte = px_s1;

	bgi_line_store #(
		.DEPTH(MAX_WIDTH)
	) u_line_store (
		.clk    (clk),
		.ctrl   (ls_ctrl),
		.rd_addr(pcol),
		.wr_addr(col_s1),
		.rd_data(ls_rd)
	);

	always_comb begin
		for (int k = 0; k < LANES; k++) begin
			fresh[k] = ls_rd[LANE_W'(lane_s1 + LANE_W'(k))];
		end
		fresh[4] = have_s1 ? px_s1 : '0;
	end

	always_ff @(posedge clk) begin
		if (shift1) begin
			for (int k = 0; k < 5; k++) begin
				for (int j = 0; j < 4; j++) begin
					win_q[k][j] <= win_q[k][j+1];
				end
				win_q[k][4] <= fresh[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy2) begin
			r_s2    <= r_s1;
			c_s2    <= c_s1;
			last_s2 <= last_s1;
		end
	end

	// mask neighbours that fall outside the frame
	always_comb begin
		r2e = (HD_W+1)'(r_s2);
		he  = (HD_W+1)'(frame_h);
		c2e = (WD_W+1)'(c_s2);
		we  = (WD_W+1)'(frame_w);
		case ({r_s2[0], c_s2[0]})
			2'b00:   site2 = SITE_RED;
			2'b11:   site2 = SITE_BLUE;
			default: site2 = SITE_GREEN;
		endcase
		nbhd.x5   = win_q[2][2];
		nbhd.g2   = (r_s2 != '0) ? win_q[1][2] : '0;
		nbhd.x1   = (r_s2 > RO_W'(1)) ? win_q[0][2] : '0;
		nbhd.g8   = ((r2e + (HD_W+1)'(1)) < he) ? win_q[3][2] : '0;
		nbhd.x9   = ((r2e + (HD_W+1)'(2)) < he) ? win_q[4][2] : '0;
		nbhd.g4   = (c_s2 != '0) ? win_q[2][1] : '0;
		nbhd.x3   = (c_s2 > COL_W'(1)) ? win_q[2][0] : '0;
		nbhd.g6   = ((c2e + (WD_W+1)'(1)) < we) ? win_q[2][3] : '0;
		nbhd.x7   = ((c2e + (WD_W+1)'(2)) < we) ? win_q[2][4] : '0;
		nbhd.site = site2;
		nbhd.last = last_s2;
	end

	bgi_interp u_interp (
		.clk   (clk),
		.en_s3 (rdy3),
		.en_s4 (rdy4),
		.nbhd  (nbhd),
		.result(result)
	);

	assign res.valid         = valid_s4;
	assign res.green         = result.green;
	assign res.mosaic_value  = result.mosaic_value;
	assign res.site_color    = result.site_color;
	assign res.last_of_frame = result.last_of_frame;

	a_win_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !rdy3) |=> $stable(win_q[2][2]))
		else $error("window moved under a held stage 2 item");

	a_out_row: assert property (@(posedge clk) disable iff (!arst_n)
		HD_W'(out_row_q) < frame_h)
		else $error("output row beyond frame height");

	a_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		(IR_W+1)'(in_row_q) <= ((IR_W+1)'(frame_h) + (IR_W+1)'(3)))
		else $error("input row ran past the drain lag");

endmodule
